// ----- src/pva_pkg.sv -----
`default_nettype none
package pva_pkg;

  localparam int VOICES     = 8;
  localparam int STAMP_BITS = 32;
  localparam int VIDX_W     = $clog2(VOICES);

  localparam logic [6:0] NOTE_RESET = 7'd48;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_ALL_OFF  = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RETRIG   = 3'd1,
    ACT_NEW      = 3'd2,
    ACT_STEAL    = 3'd3,
    ACT_RELEASED = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_RELEASE,
    WR_IDLE,
    WR_TRIGGER
  } wr_op_e;

  typedef struct packed {
    wr_op_e                  op;
    logic [VIDX_W-1:0]       idx;
    logic [6:0]              note;
    logic [6:0]              vel;
    logic [STAMP_BITS-1:0]   stamp;
  } slot_wr_t;

  typedef struct packed {
    logic                    active;
    logic                    releasing;
    logic [6:0]              note;
    logic [6:0]              vel;
    logic [STAMP_BITS-1:0]   stamp;
  } slot_rd_t;

endpackage
`default_nettype wire

// ----- src/pva_slot_file.sv -----
`default_nettype none
module pva_slot_file
  import pva_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slot_wr_t          wr_i,
  input  wire logic [VIDX_W-1:0] rd_idx_i,
  output slot_rd_t               rd_o
);

  logic                  active_q    [VOICES];
  logic                  releasing_q [VOICES];
  logic [6:0]            note_q      [VOICES];
  logic [6:0]            vel_q       [VOICES];
  logic [STAMP_BITS-1:0] stamp_q     [VOICES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        active_q[i]    <= 1'b0;
        releasing_q[i] <= 1'b0;
        vel_q[i]       <= '0;
        stamp_q[i]     <= '0;
      end
    end else begin
      case (wr_i.op)
        WR_RELEASE: begin
          releasing_q[wr_i.idx] <= 1'b1;
        end
        WR_IDLE: begin
          active_q[wr_i.idx]    <= 1'b0;
          releasing_q[wr_i.idx] <= 1'b0;
        end
        WR_TRIGGER: begin
          active_q[wr_i.idx]    <= 1'b1;
          releasing_q[wr_i.idx] <= 1'b0;
          vel_q[wr_i.idx]       <= wr_i.vel;
          stamp_q[wr_i.idx]     <= wr_i.stamp;
        end
        default: ;
      endcase
    end
  end

  // note store has no reset, only read while the slot is active
  always_ff @(posedge clk_i) begin
    if (wr_i.op == WR_TRIGGER) begin
      note_q[wr_i.idx] <= wr_i.note;
    end
  end

  always_comb begin
    rd_o.active    = active_q[rd_idx_i];
    rd_o.releasing = releasing_q[rd_idx_i];
    rd_o.note      = note_q[rd_idx_i];
    rd_o.vel       = vel_q[rd_idx_i];
    rd_o.stamp     = stamp_q[rd_idx_i];
  end

endmodule
`default_nettype wire

// ----- src/poly_voice_allocator.sv -----
`default_nettype none
// a note event passes through the accept cycle, a scan over the slots one slot a cycle, and then
// a commit cycle; voice finished skips the scan and goes from the accept cycle straight to commit
// the result strobe is high in the cycle after the commit and busy is already low there, so the
// next event is taken at the edge that ends it; no new event is taken while one is in flight
// results are shown for one cycle only; the receiver cannot stall them
// reset clears all slots to idle, stamps and counter to zero, last note to 48, glide off
module poly_voice_allocator
  import pva_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] kind_i,
  input  wire logic [6:0] note_i,
  input  wire logic [6:0] velocity_i,
  input  wire logic [2:0] voice_index_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  output logic            result_strobe_o,
  output logic [2:0]      action_o,
  output logic [2:0]      voice_o,
  output logic [6:0]      voice_note_o,
  output logic [6:0]      voice_velocity_o,
  output logic [6:0]      glide_from_note_o,
  output logic            set_pitch_now_o,
  output logic            clear_envelope_o,
  output logic [7:0]      released_mask_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_TRIG,
    OP_REL,
    OP_ALL,
    OP_FIN
  } op_e;

  state_e                state_q;
  op_e                   op_q;
  logic [VIDX_W-1:0]     cnt_q;
  logic [6:0]            note_q;
  logic [6:0]            vel_q;
  logic [2:0]            vidx_q;
  logic [7:0]            mask_q;
  logic                  hit_q;
  logic [VIDX_W-1:0]     hit_idx_q;
  logic                  free_q;
  logic [VIDX_W-1:0]     free_idx_q;
  logic [STAMP_BITS-1:0] best_q;
  logic [VIDX_W-1:0]     best_idx_q;
  logic [STAMP_BITS-1:0] trig_cnt_q;
  logic [6:0]            last_note_q;
  logic                  glide_q;

  slot_wr_t              wr;
  slot_rd_t              rd;
  logic                  note_eq;
  logic                  hit_now;
  logic                  rel_now;
  logic                  older;
  logic                  scan_last;
  logic                  fin_ok;
  logic [VIDX_W-1:0]     pick_idx;
  logic [STAMP_BITS-1:0] trig_cnt_d;
  op_e                   op_d;

  pva_slot_file u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (cnt_q),
    .rd_o     (rd)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared compare unit, looks at one slot per scan cycle
  always_comb begin
    note_eq    = (rd.note == note_q);
    hit_now    = rd.active && note_eq;
    rel_now    = rd.active && ((op_q == OP_ALL) || note_eq);
    older      = (rd.stamp < best_q);
    scan_last  = (cnt_q == VIDX_W'(VOICES - 1));
    fin_ok     = (32'(vidx_q) < 32'(VOICES));
    trig_cnt_d = trig_cnt_q + STAMP_BITS'(1);
    if (hit_q) begin
      pick_idx = hit_idx_q;
    end else if (free_q) begin
      pick_idx = free_idx_q;
    end else begin
      pick_idx = best_idx_q;
    end
  end

  always_comb begin
    case (kind_e'(kind_i))
      KIND_NOTE_ON:  op_d = (velocity_i == 7'd0) ? OP_REL : OP_TRIG;
      KIND_NOTE_OFF: op_d = OP_REL;
      KIND_ALL_OFF:  op_d = OP_ALL;
      default:       op_d = OP_FIN;
    endcase
  end

  always_comb begin
    wr.op    = WR_NONE;
    wr.idx   = cnt_q;
    wr.note  = note_q;
    wr.vel   = vel_q;
    wr.stamp = trig_cnt_d;
    if (state_q == S_SCAN) begin
      if (((op_q == OP_REL) || (op_q == OP_ALL)) && rel_now) begin
        wr.op = WR_RELEASE;
      end
    end else if (state_q == S_DONE) begin
      if (op_q == OP_TRIG) begin
        wr.op  = WR_TRIGGER;
        wr.idx = pick_idx;
      end else if ((op_q == OP_FIN) && fin_ok) begin
        wr.op  = WR_IDLE;
        wr.idx = VIDX_W'(vidx_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      op_q            <= OP_FIN;
      cnt_q           <= '0;
      trig_cnt_q      <= '0;
      last_note_q     <= NOTE_RESET;
      glide_q         <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= 1'b0;
      if (cfg_valid_i) begin
        glide_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q       <= op_d;
            note_q     <= note_i;
            vel_q      <= velocity_i;
            vidx_q     <= voice_index_i;
            cnt_q      <= '0;
            mask_q     <= '0;
            hit_q      <= 1'b0;
            hit_idx_q  <= '0;
            free_q     <= 1'b0;
            free_idx_q <= '0;
            best_q     <= '1;
            best_idx_q <= '0;
            state_q    <= (op_d == OP_FIN) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cnt_q;
          end
          if (!rd.active && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= cnt_q;
          end
          if (older) begin
            best_q     <= rd.stamp;
            best_idx_q <= cnt_q;
          end
          // slots past the eighth fall off the mask
          if (rel_now && (op_q != OP_TRIG)) begin
            mask_q <= mask_q | (8'd1 << cnt_q);
          end
          if (scan_last) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + VIDX_W'(1);
          end
        end
        S_DONE: begin
          result_strobe_o   <= 1'b1;
          action_o          <= ACT_NONE;
          voice_o           <= '0;
          voice_note_o      <= '0;
          voice_velocity_o  <= '0;
          glide_from_note_o <= '0;
          set_pitch_now_o   <= 1'b0;
          clear_envelope_o  <= 1'b0;
          released_mask_o   <= '0;
          if (op_q == OP_TRIG) begin
            trig_cnt_q       <= trig_cnt_d;
            last_note_q      <= note_q;
            voice_o          <= 3'(pick_idx);
            voice_note_o     <= note_q;
            voice_velocity_o <= vel_q;
            if (hit_q) begin
              action_o          <= ACT_RETRIG;
              glide_from_note_o <= note_q;
            end else begin
              action_o          <= free_q ? ACT_NEW : ACT_STEAL;
              glide_from_note_o <= glide_q ? last_note_q : note_q;
              set_pitch_now_o   <= 1'b1;
              clear_envelope_o  <= !free_q;
            end
          end else if ((op_q == OP_REL) || (op_q == OP_ALL)) begin
            action_o        <= (mask_q != 8'd0) ? ACT_RELEASED : ACT_NONE;
            released_mask_o <= mask_q;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
